// ===== rtl/core/morse_bit_stream_decoder_macros.svh =====
// Assertion macros for the Morse bit-stream decoder checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef MORSE_BIT_STREAM_DECODER_MACROS_SVH
`define MORSE_BIT_STREAM_DECODER_MACROS_SVH

// Check cons in the same cycle as ante; disabled while reset is applied.
`define MBSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante; disabled while reset is applied.
`define MBSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/mbsd_pkg.sv =====
// Package for the Morse bit-stream decoder: widths, character codes,
// the result record and the Morse pattern lookup. No dependencies.
package mbsd_pkg;

	localparam int MAX_SYMBOLS = 5;
	localparam int STORE_SYMS  = 5;
	localparam int MARK_W      = 3;
	localparam int GAP_W       = 2;
	localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
	localparam int BYTE_W      = 8;
	localparam int SEL_W       = 3;
	localparam int CHAR_W      = 7;

	localparam logic [GAP_W-1:0]  GAP_END   = 2'd3;
	localparam logic [MARK_W-1:0] MARK_DOT  = 3'd1;
	localparam logic [MARK_W-1:0] MARK_DASH = 3'd3;

	localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd63;
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;

	// One result word from the step logic to the output register
	typedef struct packed {
		logic              vld;
		logic [CHAR_W-1:0] ch;
	} mbsd_res_t;

	// Map symbol count and dash bits (bit i = symbol i, 1 = dash) to ASCII
	function automatic logic [CHAR_W-1:0] morse_lookup(
		input logic [CNT_W-1:0]      count,
		input logic [STORE_SYMS-1:0] bits
	);
		logic [CHAR_W-1:0] ch;
		ch = CHAR_UNKNOWN;
		if (count <= CNT_W'(STORE_SYMS)) begin
			unique case ({3'(count), bits})
				{3'd1, 5'd0}:  ch = 7'("E");
				{3'd1, 5'd1}:  ch = 7'("T");
				{3'd2, 5'd0}:  ch = 7'("I");
				{3'd2, 5'd1}:  ch = 7'("N");
				{3'd2, 5'd2}:  ch = 7'("A");
				{3'd2, 5'd3}:  ch = 7'("M");
				{3'd3, 5'd0}:  ch = 7'("S");
				{3'd3, 5'd1}:  ch = 7'("D");
				{3'd3, 5'd2}:  ch = 7'("R");
				{3'd3, 5'd3}:  ch = 7'("G");
				{3'd3, 5'd4}:  ch = 7'("U");
				{3'd3, 5'd5}:  ch = 7'("K");
				{3'd3, 5'd6}:  ch = 7'("W");
				{3'd3, 5'd7}:  ch = 7'("O");
				{3'd4, 5'd0}:  ch = 7'("H");
				{3'd4, 5'd1}:  ch = 7'("B");
				{3'd4, 5'd2}:  ch = 7'("L");
				{3'd4, 5'd3}:  ch = 7'("Z");
				{3'd4, 5'd4}:  ch = 7'("F");
				{3'd4, 5'd5}:  ch = 7'("C");
				{3'd4, 5'd6}:  ch = 7'("P");
				{3'd4, 5'd8}:  ch = 7'("V");
				{3'd4, 5'd9}:  ch = 7'("X");
				{3'd4, 5'd11}: ch = 7'("Q");
				{3'd4, 5'd13}: ch = 7'("Y");
				{3'd4, 5'd14}: ch = 7'("J");
				{3'd5, 5'd0}:  ch = 7'("5");
				{3'd5, 5'd1}:  ch = 7'("6");
				{3'd5, 5'd3}:  ch = 7'("7");
				{3'd5, 5'd7}:  ch = 7'("8");
				{3'd5, 5'd15}: ch = 7'("9");
				{3'd5, 5'd16}: ch = 7'("4");
				{3'd5, 5'd24}: ch = 7'("3");
				{3'd5, 5'd28}: ch = 7'("2");
				{3'd5, 5'd30}: ch = 7'("1");
				{3'd5, 5'd31}: ch = 7'("0");
				default:       ch = CHAR_UNKNOWN;
			endcase
		end
		return ch;
	endfunction

endpackage

// ===== rtl/core/mbsd_step.sv =====
// Per-unit decode step: mark/gap tracking, symbol collection and the
// character finish. Depends on mbsd_pkg.
module mbsd_step import mbsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [BYTE_W-1:0] data,
	input  logic [SEL_W-1:0]  key_sel,
	output mbsd_res_t         res
);

	logic [MARK_W-1:0]     mark_len_q, mark_len_d;
	logic [GAP_W-1:0]      gap_cnt_q, gap_cnt_d;
	logic [STORE_SYMS-1:0] sym_bits_q, sym_bits_d;
	logic [CNT_W-1:0]      sym_cnt_q, sym_cnt_d;
	logic                  sym_ovf_q, sym_ovf_d;
	logic                  char_end_q, char_end_d;
	logic                  key;
	logic                  add_sym;
	logic                  dash;
	logic [2:0]            sym_idx;

	assign key     = data[key_sel];
	assign dash    = (mark_len_q == MARK_DASH);
	assign add_sym = (mark_len_q == MARK_DASH) || (mark_len_q == MARK_DOT);
	assign sym_idx = 3'(sym_cnt_q);

	// Next state and result for one time unit
	always_comb begin
		mark_len_d = mark_len_q;
		gap_cnt_d  = gap_cnt_q;
		sym_bits_d = sym_bits_q;
		sym_cnt_d  = sym_cnt_q;
		sym_ovf_d  = sym_ovf_q;
		char_end_d = char_end_q;
		res.vld    = 1'b0;
		res.ch     = CHAR_SPACE;
		if (key) begin
			// extend the mark, saturating
			char_end_d = 1'b0;
			if (mark_len_q != '1) begin
				mark_len_d = mark_len_q + MARK_W'(1);
			end
		end else begin
			if (gap_cnt_q != GAP_END) begin
				gap_cnt_d = gap_cnt_q + GAP_W'(1);
			end
			if (mark_len_q != '0) begin
				// close the mark: keep dots and dashes, drop other lengths
				mark_len_d = '0;
				if (add_sym) begin
					if (sym_cnt_q < CNT_W'(MAX_SYMBOLS)) begin
						if (sym_cnt_q < CNT_W'(STORE_SYMS) && dash) begin
							sym_bits_d[sym_idx] = 1'b1;
						end
						sym_cnt_d = sym_cnt_q + CNT_W'(1);
					end else begin
						sym_ovf_d = 1'b1;
					end
				end
			end else if (gap_cnt_d == GAP_END) begin
				// finish the character or emit a word space
				if (sym_cnt_q != '0 || sym_ovf_q) begin
					res.vld = fire;
					res.ch  = sym_ovf_q ? CHAR_UNKNOWN : morse_lookup(sym_cnt_q, sym_bits_q);
				end else if (char_end_q) begin
					res.vld = fire;
					res.ch  = CHAR_SPACE;
				end
				char_end_d = 1'b1;
				sym_bits_d = '0;
				sym_cnt_d  = '0;
				sym_ovf_d  = 1'b0;
				gap_cnt_d  = '0;
			end
		end
	end

	// Commit state on each processed unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_len_q <= '0;
			gap_cnt_q  <= '0;
			sym_bits_q <= '0;
			sym_cnt_q  <= '0;
			sym_ovf_q  <= 1'b0;
			char_end_q <= 1'b0;
		end else if (fire) begin
			mark_len_q <= mark_len_d;
			gap_cnt_q  <= gap_cnt_d;
			sym_bits_q <= sym_bits_d;
			sym_cnt_q  <= sym_cnt_d;
			sym_ovf_q  <= sym_ovf_d;
			char_end_q <= char_end_d;
		end
	end

endmodule

// ===== rtl/core/mbsd_out.sv =====
// Output register for decoded characters with downstream handshake.
// Depends on mbsd_pkg.
module mbsd_out import mbsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mbsd_res_t         res,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char
);

	logic              vld_q;
	logic [CHAR_W-1:0] ch_q;

	// The register can take a new word when empty or being drained
	assign advance   = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_char  = ch_q;

	// Hold valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= res.vld;
		end
	end

	// Load payload only with a new result
	always_ff @(posedge clk) begin
		if (advance && res.vld) begin
			ch_q <= res.ch;
		end
	end

endmodule

// ===== rtl/core/morse_bit_stream_decoder.sv =====
// Morse bit-stream decoder: one byte per Morse time unit in, one ASCII
// character out per finished character or word gap. A word is accepted every
// cycle while results are taken; a unit passes the input register, then the
// combinational step logic, then the output register, which holds its result.
// Throughput is one unit per clock, and the input stalls only while the output
// register holds a word not yet taken.
// Depends on mbsd_pkg, mbsd_step and mbsd_out.
module morse_bit_stream_decoder import mbsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [6:0] decoded_char, [7] zero
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_data      // key_bit_select
);

	logic [SEL_W-1:0]  key_sel_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              advance;
	logic              fire;
	logic              s_fire;
	logic [CHAR_W-1:0] out_char;
	mbsd_res_t         res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !valid_s1 || advance;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign fire          = valid_s1 && advance;
	assign m_axis_tdata  = {1'b0, out_char};

	// Key bit select register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_sel_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			key_sel_q <= cfg_data;
		end
	end

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			data_s1 <= s_axis_tdata;
		end
	end

	mbsd_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.data    (data_s1),
		.key_sel (key_sel_q),
		.res     (res)
	);

	mbsd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char)
	);

endmodule

// ===== rtl/core/mbsd_checker.sv =====
// Port-level checks for the Morse bit-stream decoder, bound to its top level.
// Depends on morse_bit_stream_decoder_macros.svh.
`include "morse_bit_stream_decoder_macros.svh"

module mbsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	logic in_fire;
	logic out_stall;
	logic code_ok;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// Space, unknown mark, digits or capitals
	assign code_ok = (m_axis_tdata == 8'd32) || (m_axis_tdata == 8'd63) ||
		(m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57) ||
		(m_axis_tdata >= 8'd65 && m_axis_tdata <= 8'd90);

	// Hold a stalled result
	`MBSD_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "stall not held")

	// Accept input whenever the output register is empty
	`MBSD_ASSERT_SAME(a_in_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

	// A new result traces back to an accepted word, through the input and output registers
	`MBSD_ASSERT_SAME(a_out_cause, $rose(m_axis_tvalid), $past(in_fire, 2), "result without cause")

	// Only space, digits, capitals or unknown mark come out
	`MBSD_ASSERT_SAME(a_out_code, m_axis_tvalid, code_ok, "illegal character code")

endmodule

bind morse_bit_stream_decoder mbsd_checker u_mbsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
